// ===== design/assert_macros.svh =====
// assertion macros shared by the dma controller modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/dmac_pkg.sv =====
// shared types and constants of the dma channel controller
package dmac_pkg;
  localparam int NUM_CHANNELS = 10;
  localparam int GIF_MAX_BATCH = 64;
  localparam int CH_W = 4;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  localparam logic [31:0] ADDR_MASK = 32'h1FFF_FFF0;
  localparam logic [31:0] START_BIT = 32'h0000_0100;

  localparam logic [CH_W-1:0] CH_GIF = 4'd2;
  localparam logic [CH_W-1:0] CH_IPU_OUT = 4'd3;
  localparam logic [CH_W-1:0] CH_SIF0 = 4'd5;
  localparam logic [CH_W-1:0] CH_SIF1 = 4'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic            do_read;
    logic            do_write;
    logic            do_chan;
    logic            load_tag;
    logic [CH_W-1:0] chan;
    logic            last;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic                    master_en;
    logic [NUM_CHANNELS-1:0] started;
  } dp_status_t;
endpackage

// ===== design/dmac_ctrl.sv =====
// controller state machine: sequences register accesses and channel visits
`include "assert_macros.svh"
module dmac_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [1:0]             in_op,
  input  dmac_pkg::dp_status_t   status,
  output logic                   busy,
  output dmac_pkg::dp_cmd_t      cmd
);
  dmac_pkg::ctrl_state_t state_r, state_nxt;
  logic [dmac_pkg::CH_W-1:0] ch_r, ch_nxt;
  logic [dmac_pkg::NUM_CHANNELS-1:0] pend_r, pend_nxt;
  logic [dmac_pkg::NUM_CHANNELS-1:0] rest;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmac_pkg::ST_IDLE;
      ch_r <= '0;
      pend_r <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r <= ch_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r;
    pend_nxt = pend_r;
    cmd = '0;
    busy = 1'b0;
    rest = '0;
    for (int i = 0; i < dmac_pkg::NUM_CHANNELS; i++) begin
      rest[i] = pend_r[i] && (i > int'(ch_r));
    end
    case (state_r)
      dmac_pkg::ST_IDLE: begin
        if (start) begin
          case (in_op)
            dmac_pkg::OP_READ: begin
              cmd.do_read = 1'b1;
              cmd.last = 1'b1;
            end
            dmac_pkg::OP_WRITE: cmd.do_write = 1'b1;
            dmac_pkg::OP_STEP: begin
              // the tag is used later in the scan, keep the accepted one
              cmd.load_tag = 1'b1;
              if (status.master_en && (status.started != '0)) begin
                // snapshot of started channels; visits never start other channels
                pend_nxt = status.started;
                ch_nxt = '0;
                state_nxt = dmac_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      dmac_pkg::ST_SCAN: begin
        busy = 1'b1;
        if (pend_r[ch_r]) begin
          cmd.do_chan = 1'b1;
          cmd.chan = ch_r;
          cmd.last = (rest == '0);
        end
        if (rest == '0 || ch_r == 4'(dmac_pkg::NUM_CHANNELS - 1)) begin
          state_nxt = dmac_pkg::ST_DONE;
        end else begin
          ch_nxt = ch_r + 4'd1;
        end
      end
      dmac_pkg::ST_DONE: begin
        busy = 1'b1;
        state_nxt = dmac_pkg::ST_IDLE;
      end
      default: state_nxt = dmac_pkg::ST_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_no_cmd_idle_busy, clk, rst_n, busy && state_r == dmac_pkg::ST_DONE, !cmd.do_chan, "visit in done state")
  `ASSERT_IMPL(a_chan_range, clk, rst_n, cmd.do_chan, ch_r < 4'(dmac_pkg::NUM_CHANNELS), "channel out of range")
  `ASSERT_NEXT(a_last_ends, clk, rst_n, cmd.do_chan && cmd.last, state_r == dmac_pkg::ST_DONE, "last visit not final")
endmodule

// ===== design/dmac_dp.sv =====
// datapath: register file, channel update logic and result register
`include "assert_macros.svh"
module dmac_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dmac_pkg::dp_cmd_t       cmd,
  input  logic [15:0]             in_address,
  input  logic [31:0]             in_write_data,
  input  logic [63:0]             in_tag_word,
  output dmac_pkg::dp_status_t    status,
  output logic                    out_valid,
  output logic [31:0]             out_read_data,
  output logic [3:0]              out_channel,
  output logic                    out_transfer_valid,
  output logic [31:0]             out_mem_addr,
  output logic [31:0]             out_side_addr,
  output logic [6:0]              out_qw_moved,
  output logic                    out_finished,
  output logic                    out_irq,
  output logic                    out_last
);
  localparam int N = dmac_pkg::NUM_CHANNELS;
  logic [31:0] ctl_r [N], ctl_nxt [N];
  logic [31:0] mad_r [N], mad_nxt [N];
  logic [15:0] cnt_r [N], cnt_nxt [N];
  logic [31:0] tad_r [N], tad_nxt [N];
  logic [31:0] stk0_r [N], stk0_nxt [N];
  logic [31:0] stk1_r [N], stk1_nxt [N];
  logic [31:0] sad_r [N], sad_nxt [N];
  logic [31:0] g_r [9], g_nxt [9];
  logic [63:0] tag_r, tag_nxt;

  logic        v_r, v_nxt;
  logic [31:0] rd_r, rd_nxt, ma_r, ma_nxt, sa_r, sa_nxt;
  logic [3:0]  ch_r, ch_nxt;
  logic        tv_r, tv_nxt, fin_r, fin_nxt, last_r, last_nxt;
  logic [6:0]  qw_r, qw_nxt;

  logic        wsel;
  logic [3:0]  wch;
  logic [3:0]  gsel;
  logic        gval;

  // decode channel window and global register address
  always_comb begin
    wsel = 1'b1;
    wch = 4'd0;
    if (in_address < 16'h8000 || in_address >= 16'hE000) wsel = 1'b0;
    else if (in_address < 16'h9000) wch = 4'd0;
    else if (in_address < 16'hA000) wch = 4'd1;
    else if (in_address < 16'hB000) wch = 4'd2;
    else if (in_address < 16'hB400) wch = 4'd3;
    else if (in_address < 16'hC000) wch = 4'd4;
    else if (in_address < 16'hC800) wch = 4'd5;
    else if (in_address < 16'hD000) wch = 4'd6;
    else if (in_address < 16'hD400) wch = 4'd7;
    else if (in_address < 16'hD800) wch = 4'd8;
    else wch = 4'd9;
    gval = 1'b1;
    gsel = 4'd0;
    case (in_address)
      16'hE000: gsel = 4'd0;
      16'hE010: gsel = 4'd1;
      16'hE020: gsel = 4'd2;
      16'hE030: gsel = 4'd3;
      16'hE040: gsel = 4'd4;
      16'hE050: gsel = 4'd5;
      16'hE060: gsel = 4'd6;
      16'hF520: gsel = 4'd7;
      16'hF590: gsel = 4'd8;
      default: gval = 1'b0;
    endcase
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      status.started[i] = ctl_r[i][8];
    end
    status.master_en = g_r[0][0];
  end

  // per-visit working values
  logic [31:0] c_ctl, c_mad, c_tad, c_sad;
  logic [15:0] c_cnt;
  logic [15:0] n;
  logic        fin, tv;
  logic [31:0] bm, bs;
  logic [14:0] q;
  logic [2:0]  id;
  logic [31:0] taddr;
  logic        stop;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ctl_nxt[i] = ctl_r[i]; mad_nxt[i] = mad_r[i]; cnt_nxt[i] = cnt_r[i];
      tad_nxt[i] = tad_r[i]; stk0_nxt[i] = stk0_r[i]; stk1_nxt[i] = stk1_r[i];
      sad_nxt[i] = sad_r[i];
    end
    for (int j = 0; j < 9; j++) g_nxt[j] = g_r[j];
    tag_nxt = cmd.load_tag ? in_tag_word : tag_r;
    v_nxt = 1'b0; rd_nxt = '0; ch_nxt = '0; tv_nxt = 1'b0; ma_nxt = '0; sa_nxt = '0;
    qw_nxt = '0; fin_nxt = 1'b0; last_nxt = 1'b0;
    c_ctl = ctl_r[cmd.chan]; c_mad = mad_r[cmd.chan]; c_tad = tad_r[cmd.chan];
    c_sad = sad_r[cmd.chan]; c_cnt = cnt_r[cmd.chan];
    n = '0; fin = 1'b0; tv = 1'b0; bm = '0; bs = '0; stop = 1'b0;
    q = tag_r[14:0]; id = tag_r[30:28];
    taddr = tag_r[63:32] & dmac_pkg::ADDR_MASK;

    if (cmd.do_read) begin
      v_nxt = 1'b1;
      last_nxt = 1'b1;
      if (wsel) begin
        case (in_address[7:0] & 8'hFC)
          8'h00: rd_nxt = ctl_r[wch];
          8'h10: rd_nxt = mad_r[wch];
          8'h20: rd_nxt = {16'h0, cnt_r[wch]};
          8'h30: rd_nxt = tad_r[wch];
          8'h40: rd_nxt = stk0_r[wch];
          8'h50: rd_nxt = stk1_r[wch];
          default: rd_nxt = '0;
        endcase
      end else if (gval) begin
        rd_nxt = g_r[gsel];
      end
    end

    if (cmd.do_write) begin
      if (wsel) begin
        case (in_address[7:0] & 8'hFC)
          8'h00: ctl_nxt[wch] = in_write_data;
          8'h10: mad_nxt[wch] = in_write_data & dmac_pkg::ADDR_MASK;
          8'h20: cnt_nxt[wch] = in_write_data[15:0];
          8'h30: tad_nxt[wch] = in_write_data & dmac_pkg::ADDR_MASK;
          8'h40: stk0_nxt[wch] = in_write_data;
          8'h50: stk1_nxt[wch] = in_write_data;
          default: ;
        endcase
      end else if (gval) begin
        if (gsel == 4'd1) begin
          // status: write one to clear low half, mask field in upper half
          g_nxt[1] = {in_write_data[31:16], g_r[1][15:0] & ~in_write_data[15:0]};
        end else begin
          g_nxt[gsel] = in_write_data;
        end
      end
    end

    if (cmd.do_chan) begin
      if (cmd.chan == dmac_pkg::CH_GIF) begin
        if (c_ctl[3:2] == 2'd1 && c_cnt == '0) begin
          c_cnt = {1'b0, q};
          c_ctl = {tag_r[31:16], c_ctl[15:0]};
          case (id)
            3'd0: c_mad = taddr;
            3'd1: begin
              c_mad = c_tad + 32'd16;
              c_tad = c_mad + {13'h0, q, 4'h0};
            end
            3'd2: begin
              c_mad = c_tad + 32'd16;
              c_tad = taddr;
            end
            3'd3, 3'd4: begin
              c_mad = taddr;
              c_tad = c_tad + 32'd16;
            end
            3'd7: begin
              c_mad = c_tad + 32'd16;
              c_tad = '0;
              c_ctl = c_ctl & ~dmac_pkg::START_BIT;
            end
            default: begin
              fin = 1'b1;
              stop = 1'b1;
            end
          endcase
          if (!stop && tag_r[31]) begin
            fin = 1'b1;
            stop = 1'b1;
          end
        end
        if (!stop) begin
          if (c_cnt == '0) fin = 1'b1;
          else begin
            n = (c_cnt > 16'(dmac_pkg::GIF_MAX_BATCH)) ? 16'(dmac_pkg::GIF_MAX_BATCH) : c_cnt;
            tv = 1'b1; bm = c_mad;
            c_mad = c_mad + {12'h0, n, 4'h0};
            c_cnt = c_cnt - n;
            if (c_cnt == '0 && c_ctl[3:2] != 2'd1) fin = 1'b1;
          end
        end
      end else if (cmd.chan == dmac_pkg::CH_IPU_OUT) begin
        fin = 1'b1;
      end else if (cmd.chan == dmac_pkg::CH_SIF0 || cmd.chan == dmac_pkg::CH_SIF1) begin
        if (c_cnt == '0) fin = 1'b1;
        else begin
          n = (c_cnt < 16'd4) ? c_cnt : 16'd4;
          bs = c_sad;
          c_sad = c_sad + {12'h0, n, 4'h0};
          tv = 1'b1; bm = c_mad;
          c_mad = c_mad + {12'h0, n, 4'h0};
          c_cnt = c_cnt - n;
          if (c_cnt == '0) fin = 1'b1;
        end
      end else begin
        n = (c_cnt < 16'd16) ? c_cnt : 16'd16;
        tv = (n != '0);
        bm = tv ? c_mad : '0;
        c_mad = c_mad + {12'h0, n, 4'h0};
        c_cnt = c_cnt - n;
        if (c_cnt == '0) fin = 1'b1;
      end
      if (fin) begin
        c_ctl = c_ctl & ~dmac_pkg::START_BIT;
        c_cnt = '0;
        g_nxt[1] = g_r[1] | (32'd1 << cmd.chan);
      end
      ctl_nxt[cmd.chan] = c_ctl; mad_nxt[cmd.chan] = c_mad; cnt_nxt[cmd.chan] = c_cnt;
      tad_nxt[cmd.chan] = c_tad; sad_nxt[cmd.chan] = c_sad;
      v_nxt = 1'b1; ch_nxt = cmd.chan; tv_nxt = tv; ma_nxt = bm; sa_nxt = bs;
      qw_nxt = n[6:0]; fin_nxt = fin; last_nxt = cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        ctl_r[i] <= '0; mad_r[i] <= '0; cnt_r[i] <= '0; tad_r[i] <= '0;
        stk0_r[i] <= '0; stk1_r[i] <= '0; sad_r[i] <= '0;
      end
      for (int j = 0; j < 9; j++) g_r[j] <= '0;
      tag_r <= '0;
      v_r <= 1'b0;
    end else begin
      for (int i = 0; i < N; i++) begin
        ctl_r[i] <= ctl_nxt[i]; mad_r[i] <= mad_nxt[i]; cnt_r[i] <= cnt_nxt[i];
        tad_r[i] <= tad_nxt[i]; stk0_r[i] <= stk0_nxt[i]; stk1_r[i] <= stk1_nxt[i];
        sad_r[i] <= sad_nxt[i];
      end
      for (int j = 0; j < 9; j++) g_r[j] <= g_nxt[j];
      tag_r <= tag_nxt;
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r <= rd_nxt; ch_r <= ch_nxt; tv_r <= tv_nxt; ma_r <= ma_nxt; sa_r <= sa_nxt;
    qw_r <= qw_nxt; fin_r <= fin_nxt; last_r <= last_nxt;
  end

  assign out_valid = v_r;
  assign out_read_data = rd_r;
  assign out_channel = ch_r;
  assign out_transfer_valid = tv_r;
  assign out_mem_addr = ma_r;
  assign out_side_addr = sa_r;
  assign out_qw_moved = qw_r;
  assign out_finished = fin_r;
  assign out_irq = fin_r;
  assign out_last = last_r;

  `ASSERT_IMPL(a_qw_range, clk, rst_n, out_valid, out_qw_moved <= 7'd64, "batch too large")
  `ASSERT_IMPL(a_tv_qw, clk, rst_n, out_valid, out_transfer_valid == (out_qw_moved != 7'd0), "batch flag mismatch")
  `ASSERT_IMPL(a_irq_fin, clk, rst_n, out_valid, out_irq == out_finished, "irq differs from finish")
endmodule

// ===== design/dma_channel_controller.sv =====
// top level of the ten-channel dma channel controller
// Usage: drive in_op/in_address/in_write_data/in_tag_word with start high while busy is
// low; the word is taken at that clock edge. op 0 reads a register, op 1 writes one,
// op 2 runs one controller step. The step's tag word is captured at acceptance.
// A read gives one result word on the cycle after acceptance (out_valid high, out_last
// high). A write gives no result and the block stays ready.
// A step with the master enable set and at least one started channel visits channels
// 0 up to the highest started one in order, one per cycle, through the controller
// sequencer; each started channel yields one result word in the cycle after its visit,
// the final one marked by out_last. A step holds busy through the scan and done states.
// A step with nothing to do gives no result and the block stays ready.
// Results appear for exactly one cycle under out_valid; the receiver cannot stall.
// Synchronous active-low reset clears the sequencer, register file, tag and out_valid only.
module dma_channel_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [63:0] in_tag_word,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [3:0]  out_channel,
  output logic        out_transfer_valid,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_side_addr,
  output logic [6:0]  out_qw_moved,
  output logic        out_finished,
  output logic        out_irq,
  output logic        out_last
);
  dmac_pkg::dp_cmd_t    cmd;
  dmac_pkg::dp_status_t status;

  dmac_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_op(in_op),
    .status(status), .busy(busy), .cmd(cmd)
  );

  dmac_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_address(in_address),
    .in_write_data(in_write_data), .in_tag_word(in_tag_word), .status(status),
    .out_valid(out_valid), .out_read_data(out_read_data), .out_channel(out_channel),
    .out_transfer_valid(out_transfer_valid), .out_mem_addr(out_mem_addr),
    .out_side_addr(out_side_addr), .out_qw_moved(out_qw_moved),
    .out_finished(out_finished), .out_irq(out_irq), .out_last(out_last)
  );
endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench of the dma channel controller: register file and step scheduler
`timescale 1ns / 100ps

module testbench;
  localparam logic [1:0] OP_NONE = 2'd3;

  localparam logic [15:0] REG_MASTER   = 16'hE000;
  localparam logic [15:0] REG_INT_STAT = 16'hE010;
  localparam logic [15:0] REG_PRIORITY = 16'hE020;
  localparam logic [15:0] REG_SPR_QW   = 16'hE030;
  localparam logic [15:0] REG_RING_SZ  = 16'hE040;
  localparam logic [15:0] REG_RING_OFS = 16'hE050;
  localparam logic [15:0] REG_STALL    = 16'hE060;
  localparam logic [15:0] REG_EN_READ  = 16'hF520;
  localparam logic [15:0] REG_EN_WRITE = 16'hF590;

  localparam logic [7:0] OFS_CTRL  = 8'h00;
  localparam logic [7:0] OFS_MADR  = 8'h10;
  localparam logic [7:0] OFS_QWC   = 8'h20;
  localparam logic [7:0] OFS_TADR  = 8'h30;
  localparam logic [7:0] OFS_ASR0  = 8'h40;
  localparam logic [7:0] OFS_ASR1  = 8'h50;

  localparam logic [31:0] CHAIN_MODE = 32'h0000_0004;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  channel;
    logic        transfer_valid;
    logic [31:0] mem_addr;
    logic [31:0] side_addr;
    logic [6:0]  qw_moved;
    logic        finished;
    logic        irq;
    logic        last;
  } dma_word_t;

  class dma_result_tracker;
    logic [31:0] ctrl [dmac_pkg::NUM_CHANNELS];
    logic [31:0] madr [dmac_pkg::NUM_CHANNELS];
    logic [15:0] qwc  [dmac_pkg::NUM_CHANNELS];
    logic [31:0] tadr [dmac_pkg::NUM_CHANNELS];
    logic [31:0] asr0 [dmac_pkg::NUM_CHANNELS];
    logic [31:0] asr1 [dmac_pkg::NUM_CHANNELS];
    logic [31:0] sadr [dmac_pkg::NUM_CHANNELS];
    logic [31:0] master, int_stat, prio, spr_qw, ring_sz, ring_ofs, stall, en_rd, en_wr;
    dma_word_t   cur;
    dma_word_t   expected_words[$];
    int unsigned errors;

    function new();
      for (int c = 0; c < dmac_pkg::NUM_CHANNELS; c++) begin
        ctrl[c] = '0; madr[c] = '0; qwc[c] = '0; tadr[c] = '0;
        asr0[c] = '0; asr1[c] = '0; sadr[c] = '0;
      end
      master = '0; int_stat = '0; prio = '0; spr_qw = '0; ring_sz = '0;
      ring_ofs = '0; stall = '0; en_rd = '0; en_wr = '0;
      errors = 0;
    endfunction

    function int window_of(logic [15:0] a);
      if (a < 16'h8000 || a >= 16'hE000) return -1;
      if (a < 16'h9000) return 0;
      if (a < 16'hA000) return 1;
      if (a < 16'hB000) return 2;
      if (a < 16'hB400) return 3;
      if (a < 16'hC000) return 4;
      if (a < 16'hC800) return 5;
      if (a < 16'hD000) return 6;
      if (a < 16'hD400) return 7;
      if (a < 16'hD800) return 8;
      return 9;
    endfunction

    function logic [31:0] reg_value(logic [15:0] a);
      int c;
      c = window_of(a);
      if (c >= 0) begin
        case (a[7:0] & 8'hFC)
          OFS_CTRL: return ctrl[c];
          OFS_MADR: return madr[c];
          OFS_QWC:  return {16'h0, qwc[c]};
          OFS_TADR: return tadr[c];
          OFS_ASR0: return asr0[c];
          OFS_ASR1: return asr1[c];
          default:  return '0;
        endcase
      end
      case (a)
        REG_MASTER:   return master;
        REG_INT_STAT: return int_stat;
        REG_PRIORITY: return prio;
        REG_SPR_QW:   return spr_qw;
        REG_RING_SZ:  return ring_sz;
        REG_RING_OFS: return ring_ofs;
        REG_STALL:    return stall;
        REG_EN_READ:  return en_rd;
        REG_EN_WRITE: return en_wr;
        default:      return '0;
      endcase
    endfunction

    function void reg_update(logic [15:0] a, logic [31:0] v);
      int c;
      c = window_of(a);
      if (c >= 0) begin
        case (a[7:0] & 8'hFC)
          OFS_CTRL: ctrl[c] = v;
          OFS_MADR: madr[c] = v & dmac_pkg::ADDR_MASK;
          OFS_QWC:  qwc[c] = v[15:0];
          OFS_TADR: tadr[c] = v & dmac_pkg::ADDR_MASK;
          OFS_ASR0: asr0[c] = v;
          OFS_ASR1: asr1[c] = v;
          default: ;
        endcase
        return;
      end
      case (a)
        REG_MASTER: master = v;
        REG_INT_STAT: begin
          // low half is write-one-to-clear, high half is a plain mask
          int_stat = {v[31:16], int_stat[15:0] & ~v[15:0]};
        end
        REG_PRIORITY: prio = v;
        REG_SPR_QW:   spr_qw = v;
        REG_RING_SZ:  ring_sz = v;
        REG_RING_OFS: ring_ofs = v;
        REG_STALL:    stall = v;
        REG_EN_READ:  en_rd = v;
        REG_EN_WRITE: en_wr = v;
        default: ;
      endcase
    endfunction

    function void complete(int c);
      ctrl[c] = ctrl[c] & ~dmac_pkg::START_BIT;
      qwc[c] = '0;
      int_stat[c] = 1'b1;
      cur.finished = 1'b1;
      cur.irq = 1'b1;
    endfunction

    function void move_batch(int c, int unsigned n);
      cur.transfer_valid = (n != 0);
      cur.mem_addr = (n != 0) ? madr[c] : '0;
      cur.qw_moved = n[6:0];
      madr[c] = madr[c] + n * 16;
      qwc[c] = qwc[c] - n[15:0];
    endfunction

    function void gif_visit(logic [63:0] tag);
      logic [1:0]  mode;
      logic [14:0] q;
      logic [2:0]  id;
      logic [31:0] taddr;
      int unsigned n;
      int g;
      g = dmac_pkg::CH_GIF;
      mode = ctrl[g][3:2];
      if (mode == 2'd1 && qwc[g] == 0) begin
        q = tag[14:0];
        id = tag[30:28];
        taddr = tag[63:32] & dmac_pkg::ADDR_MASK;
        qwc[g] = {1'b0, q};
        ctrl[g] = {tag[31:16], ctrl[g][15:0]};
        case (id)
          3'd0: madr[g] = taddr;
          3'd1: begin
            madr[g] = tadr[g] + 16;
            tadr[g] = madr[g] + {17'h0, q} * 16;
          end
          3'd2: begin
            madr[g] = tadr[g] + 16;
            tadr[g] = taddr;
          end
          3'd3, 3'd4: begin
            madr[g] = taddr;
            tadr[g] = tadr[g] + 16;
          end
          3'd7: begin
            madr[g] = tadr[g] + 16;
            tadr[g] = '0;
            ctrl[g] = ctrl[g] & ~dmac_pkg::START_BIT;
          end
          default: begin
            complete(g);
            return;
          end
        endcase
        if (tag[31]) begin
          complete(g);
          return;
        end
      end
      if (qwc[g] == 0) begin
        complete(g);
        return;
      end
      n = (qwc[g] > dmac_pkg::GIF_MAX_BATCH) ? dmac_pkg::GIF_MAX_BATCH : qwc[g];
      move_batch(g, n);
      if (qwc[g] == 0 && mode != 2'd1) complete(g);
    endfunction

    function void channel_visit(int c, logic [63:0] tag);
      int unsigned n;
      if (c == dmac_pkg::CH_GIF) begin
        gif_visit(tag);
      end else if (c == dmac_pkg::CH_IPU_OUT) begin
        complete(c);
      end else if (c == dmac_pkg::CH_SIF0 || c == dmac_pkg::CH_SIF1) begin
        if (qwc[c] == 0) begin
          complete(c);
        end else begin
          n = (qwc[c] < 4) ? qwc[c] : 4;
          cur.side_addr = sadr[c];
          sadr[c] = sadr[c] + n * 16;
          move_batch(c, n);
          if (qwc[c] == 0) complete(c);
        end
      end else begin
        n = (qwc[c] < 16) ? qwc[c] : 16;
        move_batch(c, n);
        if (qwc[c] == 0) complete(c);
      end
    endfunction

    function void note_word(logic [1:0] op, logic [15:0] a, logic [31:0] wd,
                            logic [63:0] tag);
      int prev_count;
      prev_count = expected_words.size();
      if (op == dmac_pkg::OP_READ) begin
        cur = '0;
        cur.read_data = reg_value(a);
        cur.last = 1'b1;
        expected_words.push_back(cur);
      end else if (op == dmac_pkg::OP_WRITE) begin
        reg_update(a, wd);
      end else if (op == dmac_pkg::OP_STEP && master[0]) begin
        for (int c = 0; c < dmac_pkg::NUM_CHANNELS; c++) begin
          if (ctrl[c][8]) begin
            cur = '0;
            cur.channel = c[3:0];
            channel_visit(c, tag);
            expected_words.push_back(cur);
          end
        end
        if (expected_words.size() > prev_count)
          expected_words[expected_words.size() - 1].last = 1'b1;
      end
    endfunction

    function void field(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $display("%0t mismatch %s: expected %h actual %h", $time, name, e, a);
        errors++;
      end
    endfunction

    function void check_word(dma_word_t got);
      dma_word_t e;
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_words.pop_front();
      field("read_data", e.read_data, got.read_data);
      field("channel", e.channel, got.channel);
      field("transfer_valid", e.transfer_valid, got.transfer_valid);
      field("mem_addr", e.mem_addr, got.mem_addr);
      field("side_addr", e.side_addr, got.side_addr);
      field("qw_moved", e.qw_moved, got.qw_moved);
      field("finished", e.finished, got.finished);
      field("irq", e.irq, got.irq);
      field("last", e.last, got.last);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = dmac_pkg::OP_READ;
  logic [15:0] in_address = '0;
  logic [31:0] in_write_data = '0;
  logic [63:0] in_tag_word = '0;
  logic        out_valid;
  logic [31:0] out_read_data;
  logic [3:0]  out_channel;
  logic        out_transfer_valid;
  logic [31:0] out_mem_addr;
  logic [31:0] out_side_addr;
  logic [6:0]  out_qw_moved;
  logic        out_finished;
  logic        out_irq;
  logic        out_last;

  dma_result_tracker tracker = new();
  int unsigned quiet_cycles = 0;
  int burst_left = 0;

  always #10 clk = ~clk;

  dma_channel_controller i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_address(in_address), .in_write_data(in_write_data),
    .in_tag_word(in_tag_word), .out_valid(out_valid), .out_read_data(out_read_data),
    .out_channel(out_channel), .out_transfer_valid(out_transfer_valid),
    .out_mem_addr(out_mem_addr), .out_side_addr(out_side_addr),
    .out_qw_moved(out_qw_moved), .out_finished(out_finished), .out_irq(out_irq),
    .out_last(out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_word({out_read_data, out_channel, out_transfer_valid, out_mem_addr,
                          out_side_addr, out_qw_moved, out_finished, out_irq, out_last});
  end

  // watchdog: cycles in which no word moves on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start stays high across back-to-back words; gaps come at burst ends
  task automatic send(logic [1:0] op, logic [15:0] a, logic [31:0] wd, logic [63:0] tag);
    start <= 1'b1;
    in_op <= op;
    in_address <= a;
    in_write_data <= wd;
    in_tag_word <= tag;
    do @(posedge clk); while (busy);
    tracker.note_word(op, a, wd, tag);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 8);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] chan_reg(int c, logic [7:0] ofs);
    logic [15:0] bases [dmac_pkg::NUM_CHANNELS];
    logic [15:0] a;
    bases = '{16'h8000, 16'h9000, 16'hA000, 16'hB000, 16'hB400,
              16'hC000, 16'hC800, 16'hD000, 16'hD400, 16'hD800};
    a = bases[c] + {8'h0, ofs};
    if ($urandom_range(0, 2) == 0) a = a | (16'($urandom) & 16'h0303);
    return a;
  endfunction

  function automatic logic [63:0] chain_tag();
    logic [63:0] t;
    t = {$urandom, $urandom};
    t[14:0] = ($urandom_range(0, 4) == 0) ? 15'($urandom) : 15'($urandom_range(0, 70));
    t[31] = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  function automatic logic [15:0] global_reg();
    logic [15:0] regs [9];
    regs = '{REG_MASTER, REG_INT_STAT, REG_PRIORITY, REG_SPR_QW, REG_RING_SZ,
             REG_RING_OFS, REG_STALL, REG_EN_READ, REG_EN_WRITE};
    return regs[$urandom_range(0, 8)];
  endfunction

  task automatic random_word();
    int c;
    logic [31:0] v;
    c = $urandom_range(0, dmac_pkg::NUM_CHANNELS - 1);
    v = $urandom;
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        v[8] = ($urandom_range(0, 3) != 0);
        if (c == dmac_pkg::CH_GIF && $urandom_range(0, 2) != 0) v[3:2] = 2'd1;
        send(dmac_pkg::OP_WRITE, chan_reg(c, OFS_CTRL), v, chain_tag());
      end
      3, 4: send(dmac_pkg::OP_WRITE, chan_reg(c, OFS_QWC),
                 ($urandom_range(0, 5) == 0) ? v : $urandom_range(0, 40), chain_tag());
      5: send(dmac_pkg::OP_WRITE, chan_reg(c, OFS_MADR), v, chain_tag());
      6: send(dmac_pkg::OP_WRITE, chan_reg(c, ($urandom_range(0, 2) == 0) ? OFS_ASR0 :
              ($urandom_range(0, 1) ? OFS_ASR1 : OFS_TADR)), v, chain_tag());
      7, 8, 9, 10, 11, 12: send(dmac_pkg::OP_STEP, 16'($urandom), v, chain_tag());
      13, 14: send(dmac_pkg::OP_READ,
                   ($urandom_range(0, 1) ? chan_reg(c, 8'($urandom_range(0, 5) * 16))
                   : global_reg()), v, chain_tag());
      15: begin
        if (global_reg() == REG_MASTER || $urandom_range(0, 1)) v[0] = ($urandom_range(0, 5) != 0);
        send(dmac_pkg::OP_WRITE, ($urandom_range(0, 1) ? REG_MASTER : global_reg()), v,
             chain_tag());
      end
      16: send(dmac_pkg::OP_WRITE, REG_INT_STAT, v, chain_tag());
      default: send(2'($urandom), 16'($urandom), v, {$urandom, $urandom});
    endcase
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(dmac_pkg::OP_WRITE, REG_MASTER, 32'h1, '0);
    send(dmac_pkg::OP_READ, REG_MASTER, '0, '0);
    send(dmac_pkg::OP_STEP, '0, '0, '1);
    send(dmac_pkg::OP_WRITE, chan_reg(0, OFS_QWC), 32'd20, '0);
    send(dmac_pkg::OP_WRITE, chan_reg(0, OFS_MADR), 32'hFFFF_FFFF, '0);
    send(dmac_pkg::OP_WRITE, chan_reg(0, OFS_CTRL), dmac_pkg::START_BIT, '0);
    send(dmac_pkg::OP_WRITE, chan_reg(3, OFS_CTRL), dmac_pkg::START_BIT, '0);
    send(dmac_pkg::OP_WRITE, chan_reg(5, OFS_QWC), 32'd6, '0);
    send(dmac_pkg::OP_WRITE, chan_reg(5, OFS_CTRL), dmac_pkg::START_BIT, '0);
    send(dmac_pkg::OP_STEP, '0, '0, '0);
    send(dmac_pkg::OP_STEP, '0, '0, '0);
    send(dmac_pkg::OP_READ, REG_INT_STAT, '0, '0);
    send(dmac_pkg::OP_WRITE, REG_INT_STAT, 32'hABCD_0009, '0);
    send(dmac_pkg::OP_READ, REG_INT_STAT, '0, '0);
    // gif chain: next-tag, end tag with a long batch, tag interrupt, bad id
    send(dmac_pkg::OP_WRITE, chan_reg(2, OFS_TADR), 32'h0000_1000, '0);
    send(dmac_pkg::OP_WRITE, chan_reg(2, OFS_CTRL), dmac_pkg::START_BIT | CHAIN_MODE, '0);
    send(dmac_pkg::OP_STEP, '0, '0, 64'h0000_0000_1000_0003);
    send(dmac_pkg::OP_STEP, '0, '0, 64'h1234_5678_7000_0046);
    send(dmac_pkg::OP_WRITE, chan_reg(2, OFS_CTRL), dmac_pkg::START_BIT | CHAIN_MODE, '0);
    send(dmac_pkg::OP_STEP, '0, '0, 64'hFFFF_FFFF_8000_0002);
    send(dmac_pkg::OP_WRITE, chan_reg(2, OFS_CTRL), dmac_pkg::START_BIT | CHAIN_MODE, '0);
    send(dmac_pkg::OP_STEP, '0, '0, 64'h0000_0000_5000_0000);
    send(dmac_pkg::OP_WRITE, REG_MASTER, 32'h0, '0);
    send(dmac_pkg::OP_STEP, '0, '0, '0);
    send(dmac_pkg::OP_READ, 16'hFFFF, '0, '0);
    send(dmac_pkg::OP_WRITE, 16'h0000, 32'hFFFF_FFFF, '0);
    send(OP_NONE, REG_MASTER, 32'h1, '0);
    send(dmac_pkg::OP_WRITE, REG_MASTER, 32'h1, '0);

    drain();
    for (int i = 0; i < 150; i++) begin
      random_word();
      if (i == 75) drain();
    end

    drain();
    repeat (15) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== dma_channel_controller.f =====
+incdir+design
design/dmac_pkg.sv
design/dmac_ctrl.sv
design/dmac_dp.sv
design/dma_channel_controller.sv
tb/sv/testbench.sv
